FILE: src/counting_semaphore_unit_top_assert.svh
// ---------------------------------------------------------------------------
// counting semaphore unit assertion macros
// property wrappers shared by the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_UNIT_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_UNIT_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/csu_pkg.sv
// ---------------------------------------------------------------------------
// counting semaphore unit package
// field widths, default sizes and the operation, status and state codes
// ---------------------------------------------------------------------------
package csu_pkg;

    localparam int ID_W   = 4;
    localparam int PROC_W = 4;
    localparam int INIT_W = 8;
    localparam int CNT_W  = 9;

    localparam int DEF_NUM_SEMS = 16;
    localparam int DEF_MAX_PROC = 16;

    localparam logic signed [CNT_W-1:0] COUNT_MAX = 9'sd255;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_SIGNAL = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BLOCKED = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_QUEUE
    } state_t;

endpackage

FILE: src/counting_semaphore_unit_top.sv
// ---------------------------------------------------------------------------
// counting semaphore unit
// table of counting semaphores, each with a fifo of waiting process ids
// ---------------------------------------------------------------------------
// usage
//   operations come in on the s_ channel (mode in s_tuser, operands in
//   s_tdata), one result per operation leaves on the m_ channel (status in
//   m_tuser, woken process and resulting count in m_tdata).
//   the block works on one operation at a time. the transfer cycle reads
//   the semaphore table, the next cycle decides; a signal that releases a
//   waiter then reads the wait queue before it writes back. the write-back
//   waits until the output register is free and loads the result into it;
//   s_tready rises in the same cycle as m_tvalid, so a new operation is
//   taken only after the one in hand has written back.
//   this order comes from the single read port of the semaphore table and
//   the read-modify-write that follows it.
//   the result sits in an output register; while the receiver stalls, the
//   operation in hand waits at its write-back and the table stays untouched.
//   reset clears every valid bit, so all semaphores read as uninitialized;
//   no clearing pass is needed and s_tready is high right after reset.
// ---------------------------------------------------------------------------
module counting_semaphore_unit_top #(
    parameter int NUM_SEMS = csu_pkg::DEF_NUM_SEMS,
    parameter int MAX_PROC = csu_pkg::DEF_MAX_PROC
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sem_id[3:0], proc_id[7:4], init_count[15:8]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // woken_valid[0], woken_proc[4:1], count_after[13:5], 0
    output logic [1:0]  m_tuser    // status[1:0]
);

    import csu_pkg::*;

    localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int HEAD_W = $clog2(MAX_PROC);
    localparam int LEN_W  = $clog2(MAX_PROC + 1);
    localparam int ENT_W  = CNT_W + HEAD_W + LEN_W;
    localparam int QDEPTH = NUM_SEMS * MAX_PROC;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    state_t state_reg, state_next;

    mode_t                    op_reg;
    logic [SEM_AW-1:0]        idx_reg;
    logic                     known_reg;
    logic [PROC_W-1:0]        proc_reg;
    logic [INIT_W-1:0]        init_reg;
    logic [NUM_SEMS-1:0]      valid_reg, valid_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic                     out_wv_reg, out_wv_next;
    logic [PROC_W-1:0]        out_wp_reg, out_wp_next;
    logic signed [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                     accept;
    logic                     out_free;
    logic                     commit;
    logic                     q_rd_en;

    logic [ID_W-1:0]          in_sem_id;
    logic [ENT_W-1:0]         tbl_rd_data;
    logic [ENT_W-1:0]         tbl_wr_data;
    logic                     tbl_we;
    logic [PROC_W-1:0]        q_rd_data;
    logic                     q_we;
    logic [QAW-1:0]           q_addr;

    logic signed [CNT_W-1:0]  ent_count, new_count;
    logic [HEAD_W-1:0]        ent_head, new_head, head_inc;
    logic [LEN_W-1:0]         ent_len, new_len;
    logic                     ent_valid;
    logic                     need_queue;
    logic [LEN_W:0]           tail_sum;
    logic [HEAD_W-1:0]        tail_slot;
    logic [QAW-1:0]           q_base;
    logic                     do_enqueue;

    assign in_sem_id = s_tdata[ID_W-1:0];
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign {ent_count, ent_head, ent_len} = tbl_rd_data;
    assign ent_valid  = known_reg && valid_reg[idx_reg];
    assign need_queue = (op_reg == MODE_SIGNAL) && ent_valid && (ent_len != '0);

    // ring position behind the newest waiter, head plus length wraps once at most
    assign tail_sum  = (LEN_W + 1)'(ent_head) + (LEN_W + 1)'(ent_len);
    assign tail_slot = (tail_sum >= (LEN_W + 1)'(MAX_PROC))
                       ? HEAD_W'(tail_sum - (LEN_W + 1)'(MAX_PROC))
                       : HEAD_W'(tail_sum);
    assign head_inc  = (ent_head == HEAD_W'(MAX_PROC - 1)) ? '0 : ent_head + 1'b1;
    assign q_base    = QAW'(idx_reg) * QAW'(MAX_PROC);
    assign q_addr    = q_base + QAW'(do_enqueue ? tail_slot : ent_head);

    csu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SEMS)
    ) u_sem_table (
        .clk     (clk),
        .wr_en   (tbl_we && commit),
        .wr_addr (idx_reg),
        .wr_data (tbl_wr_data),
        .rd_en   (accept),
        .rd_addr (SEM_AW'(in_sem_id)),
        .rd_data (tbl_rd_data)
    );

    csu_ram #(
        .WIDTH (PROC_W),
        .DEPTH (QDEPTH)
    ) u_wait_queue (
        .clk     (clk),
        .wr_en   (q_we && commit),
        .wr_addr (q_addr),
        .wr_data (proc_reg),
        .rd_en   (q_rd_en),
        .rd_addr (q_addr),
        .rd_data (q_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (need_queue)
                begin
                    state_next = S_QUEUE;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_QUEUE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        q_rd_en  = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                q_rd_en = need_queue;
                commit  = !need_queue && out_free;
            end
            S_QUEUE:
            begin
                commit = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // operation datapath
    always_comb
    begin
        out_status_next = STAT_OK;
        out_wv_next     = 1'b0;
        out_wp_next     = '0;
        out_cnt_next    = ent_count;
        new_count       = ent_count;
        new_head        = ent_head;
        new_len         = ent_len;
        tbl_we          = 1'b0;
        q_we            = 1'b0;
        do_enqueue      = 1'b0;
        valid_next      = valid_reg;
        if (!known_reg)
        begin
            out_status_next = STAT_UNKNOWN;
            out_cnt_next    = '0;
        end
        else if (op_reg == MODE_INIT)
        begin
            tbl_we              = 1'b1;
            new_count           = CNT_W'(init_reg);
            new_head            = '0;
            new_len             = '0;
            out_cnt_next        = CNT_W'(init_reg);
            valid_next[idx_reg] = commit ? 1'b1 : valid_reg[idx_reg];
        end
        else if (!ent_valid)
        begin
            out_status_next = STAT_UNKNOWN;
            out_cnt_next    = '0;
        end
        else
        begin
            unique case (op_reg)
                MODE_WAIT:
                begin
                    if (ent_count > 0)
                    begin
                        tbl_we       = 1'b1;
                        new_count    = ent_count - CNT_W'(1);
                        out_cnt_next = ent_count - CNT_W'(1);
                    end
                    else if (ent_len == LEN_W'(MAX_PROC))
                    begin
                        out_status_next = STAT_FULL;
                    end
                    else
                    begin
                        tbl_we          = 1'b1;
                        q_we            = 1'b1;
                        do_enqueue      = 1'b1;
                        new_len         = ent_len + 1'b1;
                        new_count       = ent_count - CNT_W'(1);
                        out_cnt_next    = ent_count - CNT_W'(1);
                        out_status_next = STAT_BLOCKED;
                    end
                end
                MODE_SIGNAL:
                begin
                    if (ent_len != '0)
                    begin
                        tbl_we       = 1'b1;
                        new_head     = head_inc;
                        new_len      = ent_len - 1'b1;
                        new_count    = ent_count + CNT_W'(1);
                        out_cnt_next = ent_count + CNT_W'(1);
                        out_wv_next  = 1'b1;
                        out_wp_next  = q_rd_data;
                    end
                    else if (ent_count < COUNT_MAX)
                    begin
                        tbl_we       = 1'b1;
                        new_count    = ent_count + CNT_W'(1);
                        out_cnt_next = ent_count + CNT_W'(1);
                    end
                end
                MODE_INIT, MODE_NONE:
                begin
                    out_cnt_next = ent_count;
                end
                default:
                begin
                    out_cnt_next = ent_count;
                end
            endcase
        end
        tbl_wr_data = {new_count, new_head, new_len};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= mode_t'(s_tuser);
            idx_reg   <= SEM_AW'(in_sem_id);
            known_reg <= (9'(in_sem_id) < 9'(NUM_SEMS));
            proc_reg  <= s_tdata[ID_W +: PROC_W];
            init_reg  <= s_tdata[ID_W + PROC_W +: INIT_W];
        end
        if (commit)
        begin
            out_status_reg <= out_status_next;
            out_wv_reg     <= out_wv_next;
            out_wp_reg     <= out_wp_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_wp_reg, out_wv_reg};

    `include "counting_semaphore_unit_top_assert.svh"

    `CSU_ASSERT_NOW(a_blocked_negative, m_tvalid && (m_tuser == STAT_BLOCKED),
        $signed(m_tdata[13:5]) < 0 && !m_tdata[0],
        "blocked caller with non-negative count or a woken process")
    `CSU_ASSERT_NOW(a_woken_ok, m_tvalid && m_tdata[0], m_tuser == STAT_OK,
        "woken process reported with a status other than ok")
    `CSU_ASSERT_NOW(a_unknown_clean, m_tvalid && (m_tuser == STAT_UNKNOWN),
        m_tdata[13:0] == '0, "unknown semaphore result carries data")
    `CSU_ASSERT_NEXT(a_one_in_flight, accept, !s_tready,
        "new operation taken while one is in hand")

endmodule

FILE: src/csu_ram.sv
// ---------------------------------------------------------------------------
// generic simple dual-port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module csu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: dv/tb_counting_semaphore_unit_top.sv
// ---------------------------------------------------------------------------
// counting semaphore unit testbench
// drives init, wait, signal and unused operations with random gaps and
// stalls on both streams, tracks every semaphore count and wait queue in a
// scoreboard and compares each result field by field in transfer order
// ---------------------------------------------------------------------------
import csu_pkg::*;

localparam int SEMS  = csu_pkg::DEF_NUM_SEMS;
localparam int PROCS = csu_pkg::DEF_MAX_PROC;

typedef struct packed {
    status_t                  status;
    logic                     woken_valid;
    logic [PROC_W-1:0]        woken_proc;
    logic signed [CNT_W-1:0]  count_after;
} sem_result_t;

class sem_scoreboard;
    bit                       sem_live  [SEMS];
    logic signed [CNT_W-1:0]  sem_cnt   [SEMS];
    logic [PROC_W-1:0]        waiter    [SEMS][PROCS];
    int                       head      [SEMS];
    int                       depth     [SEMS];
    sem_result_t              expected_q[$];
    int                       errors;

    function new();
        for (int i = 0; i < SEMS; i++)
        begin
            sem_live[i] = 1'b0;
            sem_cnt[i]  = '0;
            head[i]     = 0;
            depth[i]    = 0;
        end
        errors = 0;
    endfunction

    // apply one accepted operation to the semaphore table, queue its result
    function void note_op(mode_t mode, logic [ID_W-1:0] id, logic [PROC_W-1:0] proc,
                          logic [INIT_W-1:0] init);
        sem_result_t r;
        int          slot;
        r = '0;
        if (id >= SEMS)
            r.status = STAT_UNKNOWN;
        else if (mode == MODE_INIT)
        begin
            // re-init drops any waiters
            sem_live[id]  = 1'b1;
            sem_cnt[id]   = {1'b0, init};
            head[id]      = 0;
            depth[id]     = 0;
            r.count_after = sem_cnt[id];
        end
        else if (!sem_live[id])
            r.status = STAT_UNKNOWN;
        else
        begin
            case (mode)
                MODE_WAIT:
                begin
                    if (sem_cnt[id] > 0)
                        sem_cnt[id] = sem_cnt[id] - CNT_W'(1);
                    else if (depth[id] >= PROCS)
                        r.status = STAT_FULL;
                    else
                    begin
                        slot              = (head[id] + depth[id]) % PROCS;
                        waiter[id][slot]  = proc;
                        depth[id]         = depth[id] + 1;
                        sem_cnt[id]       = sem_cnt[id] - CNT_W'(1);
                        r.status          = STAT_BLOCKED;
                    end
                end
                MODE_SIGNAL:
                begin
                    if (depth[id] > 0)
                    begin
                        r.woken_valid = 1'b1;
                        r.woken_proc  = waiter[id][head[id]];
                        head[id]      = (head[id] + 1) % PROCS;
                        depth[id]     = depth[id] - 1;
                        sem_cnt[id]   = sem_cnt[id] + CNT_W'(1);
                    end
                    else if (sem_cnt[id] < COUNT_MAX)
                        sem_cnt[id] = sem_cnt[id] + CNT_W'(1);
                end
                default: ;
            endcase
            r.count_after = sem_cnt[id];
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(sem_result_t got);
        sem_result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result with nothing expected: status %0d woken %0d/%0d count %0d",
                         got.status, got.woken_valid, got.woken_proc, got.count_after);
            return;
        end
        want = expected_q.pop_front();
        if (got.status != want.status || got.woken_valid != want.woken_valid ||
            got.woken_proc != want.woken_proc || got.count_after != want.count_after)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: status %0d/%0d wv %0d/%0d wp %0d/%0d cnt %0d/%0d (exp/got)",
                         want.status, got.status, want.woken_valid, got.woken_valid,
                         want.woken_proc, got.woken_proc, want.count_after, got.count_after);
        end
    endfunction
endclass

module tb_counting_semaphore_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // sem_id[3:0], proc_id[7:4], init_count[15:8]
    logic [1:0]  s_tuser;    // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // woken_valid[0], woken_proc[4:1], count_after[13:5], 0
    logic [1:0]  m_tuser;    // status[1:0]

    sem_scoreboard sb;
    bit            quiet;
    int            hold_trig;
    int            op_count;

    always #4 clk = ~clk;

    counting_semaphore_unit_top #(
        .NUM_SEMS (SEMS),
        .MAX_PROC (PROCS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic send_op(mode_t mode, logic [ID_W-1:0] id, logic [PROC_W-1:0] proc,
                           logic [INIT_W-1:0] init);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {init, proc, id};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_op(mode, id, proc, init);
        op_count++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_op(int init_pct, int wait_pct, int sig_pct,
                             logic [ID_W-1:0] hot_a, logic [ID_W-1:0] hot_b);
        int                r;
        mode_t             mode;
        logic [ID_W-1:0]   id;
        logic [INIT_W-1:0] init;
        r = $urandom_range(0, 99);
        if (r < init_pct)
            mode = MODE_INIT;
        else if (r < init_pct + wait_pct)
            mode = MODE_WAIT;
        else if (r < init_pct + wait_pct + sig_pct)
            mode = MODE_SIGNAL;
        else
            mode = MODE_NONE;
        r = $urandom_range(0, 99);
        if (r < 43)
            id = hot_a;
        else if (r < 85)
            id = hot_b;
        else
            id = ID_W'($urandom_range(0, SEMS - 1));
        init = INIT_W'($urandom_range(0, 255));
        if (mode == MODE_INIT)
        begin
            // small counts let queues build, counts near the top reach saturation
            r = $urandom_range(0, 9);
            if (r < 5)
                init = INIT_W'($urandom_range(0, 3));
            else if (r < 7)
                init = INIT_W'($urandom_range(250, 255));
        end
        send_op(mode, id, PROC_W'($urandom_range(0, PROCS - 1)), init);
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        int stall_left;
        int hold_seen;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_seen  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_trig != hold_seen)
            begin
                hold_seen  = hold_trig;
                stall_left = 150;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = idle_len();
                m_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{status_t'(m_tuser), m_tdata[0], m_tdata[4:1], m_tdata[13:5]});
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int                phase;
        int                kind;
        logic [ID_W-1:0]   hot_a;
        logic [ID_W-1:0]   hot_b;
        sb        = new();
        quiet     = 1'b0;
        hold_trig = 0;
        op_count  = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_INIT;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // uninitialized semaphore in wait, signal and unused modes
        send_op(MODE_WAIT,   4'd3,  4'd7,  8'd0);
        send_op(MODE_SIGNAL, 4'd3,  4'd7,  8'd0);
        send_op(MODE_NONE,   4'd3,  4'd7,  8'd0);
        // blocking, fifo wake order, then counting up
        send_op(MODE_INIT,   4'd0,  4'd0,  8'd0);
        send_op(MODE_WAIT,   4'd0,  4'd15, 8'd0);
        send_op(MODE_WAIT,   4'd0,  4'd0,  8'd0);
        send_op(MODE_NONE,   4'd0,  4'd0,  8'd0);
        send_op(MODE_SIGNAL, 4'd0,  4'd0,  8'd0);
        send_op(MODE_SIGNAL, 4'd0,  4'd0,  8'd0);
        send_op(MODE_SIGNAL, 4'd0,  4'd0,  8'd0);
        send_op(MODE_WAIT,   4'd0,  4'd9,  8'd0);
        // count saturates at the top
        send_op(MODE_INIT,   4'd15, 4'd0,  8'd255);
        send_op(MODE_SIGNAL, 4'd15, 4'd0,  8'd0);
        send_op(MODE_WAIT,   4'd15, 4'd10, 8'd0);
        // re-init with a waiter queued
        send_op(MODE_INIT,   4'd0,  4'd0,  8'd0);
        send_op(MODE_WAIT,   4'd0,  4'd5,  8'd0);
        send_op(MODE_INIT,   4'd0,  4'd0,  8'd3);
        send_op(MODE_SIGNAL, 4'd0,  4'd0,  8'd0);
        send_op(MODE_INIT,   4'd9,  4'd10, 8'd170);
        send_op(MODE_INIT,   4'd6,  4'd5,  8'd85);
        // fill a queue past its depth
        send_op(MODE_INIT,   4'd1,  4'd0,  8'd0);
        for (int i = 0; i < PROCS + 1; i++)
            send_op(MODE_WAIT, 4'd1, i[PROC_W-1:0], 8'd0);
        drain();

        phase = 0;
        while (op_count < 1150)
        begin
            kind  = phase % 3;
            quiet = (phase % 5 == 3);
            hot_a = ID_W'($urandom_range(0, SEMS - 1));
            hot_b = ID_W'($urandom_range(0, SEMS - 1));
            if (phase == 3)
                hold_trig++;
            for (int i = 0; i < 100; i++)
            begin
                case (kind)
                    0: random_op(5, 45, 45, hot_a, hot_b);
                    1: random_op(1, 75, 22, hot_a, hot_b);
                    default: random_op(3, 30, 65, hot_a, hot_b);
                endcase
            end
            if (phase % 4 == 1)
                drain();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
